[rtl/flht_pkg.sv]
// Shared types, constants and speed tables for the fan level hysteresis unit.
// Used by every module of the unit; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package flht_pkg;

  // Default number of fan levels and size of the speed tables.
  localparam int NUM_LEVELS_DEF = 8;
  localparam int TABLE_LEVELS   = 8;
  localparam int NUM_SENSORS    = 3;

  // Input beat: channel, mode and the three sensor readings.
  typedef struct packed {
    logic              fan_channel;
    logic              tablet_sel;
    logic signed [7:0] temp_first;
    logic signed [7:0] temp_third;
    logic signed [7:0] temp_fourth;
  } in_t;

  // Result beat: target speed and the level after the update.
  typedef struct packed {
    logic [15:0] target_rpm;
    logic [2:0]  fan_level;
  } out_t;

  typedef logic signed [7:0] temp_t;

  // What one sensor lane reports.
  typedef struct packed {
    logic fell;
    logic rose;
    logic over_trip;
    logic under_rel;
  } lane_flags_t;

  // What the merge stage hands to the level sequencer.
  typedef struct packed {
    logic fell;
    logic rose;
    logic step_up;
    logic step_down;
  } step_ctl_t;

  // Trigger points per mode, level and sensor (first, third, fourth).
  localparam temp_t TRIP_TAB [2][TABLE_LEVELS][NUM_SENSORS] = '{
    '{ '{8'sd0,   8'sd54,  8'sd34},
       '{8'sd0,   8'sd57,  8'sd35},
       '{8'sd0,   8'sd58,  8'sd36},
       '{8'sd0,   8'sd59,  8'sd37},
       '{8'sd60,  8'sd60,  8'sd38},
       '{8'sd62,  8'sd61,  8'sd39},
       '{8'sd65,  8'sd64,  8'sd40},
       '{8'sd100, 8'sd100, 8'sd100} },
    '{ '{8'sd0,   8'sd55,  8'sd39},
       '{8'sd0,   8'sd56,  8'sd40},
       '{8'sd0,   8'sd57,  8'sd41},
       '{8'sd0,   8'sd58,  8'sd42},
       '{8'sd60,  8'sd59,  8'sd43},
       '{8'sd62,  8'sd60,  8'sd44},
       '{8'sd65,  8'sd61,  8'sd45},
       '{8'sd100, 8'sd100, 8'sd100} }
  };

  // Release points per mode, level and sensor (first, third, fourth).
  localparam temp_t REL_TAB [2][TABLE_LEVELS][NUM_SENSORS] = '{
    '{ '{8'sd99, 8'sd99, 8'sd99},
       '{8'sd99, 8'sd54, 8'sd34},
       '{8'sd99, 8'sd57, 8'sd35},
       '{8'sd99, 8'sd58, 8'sd36},
       '{8'sd58, 8'sd59, 8'sd37},
       '{8'sd60, 8'sd60, 8'sd38},
       '{8'sd62, 8'sd61, 8'sd39},
       '{8'sd65, 8'sd62, 8'sd40} },
    '{ '{8'sd99, 8'sd99, 8'sd99},
       '{8'sd99, 8'sd55, 8'sd39},
       '{8'sd99, 8'sd56, 8'sd40},
       '{8'sd99, 8'sd57, 8'sd41},
       '{8'sd58, 8'sd58, 8'sd42},
       '{8'sd60, 8'sd59, 8'sd43},
       '{8'sd62, 8'sd60, 8'sd44},
       '{8'sd65, 8'sd61, 8'sd45} }
  };

  // Target speed per mode, level and fan channel.
  localparam logic [15:0] RPM_TAB [2][TABLE_LEVELS][2] = '{
    '{ '{16'd0,    16'd0},
       '{16'd3950, 16'd3850},
       '{16'd4200, 16'd4100},
       '{16'd4550, 16'd4450},
       '{16'd4900, 16'd4800},
       '{16'd5250, 16'd5150},
       '{16'd5400, 16'd5300},
       '{16'd6000, 16'd6150} },
    '{ '{16'd0,    16'd0},
       '{16'd0,    16'd0},
       '{16'd4000, 16'd3350},
       '{16'd4200, 16'd3400},
       '{16'd4400, 16'd3500},
       '{16'd4800, 16'd4350},
       '{16'd5000, 16'd4500},
       '{16'd5200, 16'd5100} }
  };

endpackage

`default_nettype wire

[rtl/flht_lane.sv]
// One sensor lane: compares a reading with its previous value and with the
// trigger and release points of the current level. Uses flht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module flht_lane (
  input  wire flht_pkg::temp_t  temp,
  input  wire flht_pkg::temp_t  last_temp,
  input  wire flht_pkg::temp_t  trip,
  input  wire flht_pkg::temp_t  rel,
  output flht_pkg::lane_flags_t flags
);

  // All comparisons are signed degrees.
  always_comb begin
    flags.fell      = temp < last_temp;
    flags.rose      = temp > last_temp;
    flags.over_trip = temp > trip;
    flags.under_rel = temp < rel;
  end

endmodule

`default_nettype wire

[rtl/flht_merge.sv]
// Merge stage: combines the three sensor lanes into the direction of the
// reading change and the step decision for the current level. Uses flht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module flht_merge (
  input  wire flht_pkg::lane_flags_t lane_first,
  input  wire flht_pkg::lane_flags_t lane_third,
  input  wire flht_pkg::lane_flags_t lane_fourth,
  output flht_pkg::step_ctl_t        ctl
);

  always_comb begin
    // Any sensor that moved raises fell or rose; the sequencer lets a fall win over a rise.
    ctl.fell = lane_first.fell | lane_third.fell | lane_fourth.fell;
    ctl.rose = lane_first.rose | lane_third.rose | lane_fourth.rose;
    // Step up when first and fourth both trip, or when third trips alone.
    ctl.step_up = (lane_first.over_trip & lane_fourth.over_trip) | lane_third.over_trip;
    // Step down only when every sensor is below its release point.
    ctl.step_down = lane_first.under_rel & lane_third.under_rel & lane_fourth.under_rel;
  end

endmodule

`default_nettype wire

[rtl/fan_level_hysteresis_table_unit.sv]
// Top level of the fan level hysteresis unit: level sequencer, sensor lanes,
// merge stage and result register. Uses flht_pkg, flht_lane and flht_merge.
//
//   Channel | Ports                          | Direction | Beat
//   --------+--------------------------------+-----------+--------------------
//   input   | in_valid, in_ready, in_data    | in        | flht_pkg::in_t
//   result  | out_valid, out_ready, out_data | out       | flht_pkg::out_t
//
// One beat is processed at a time. A beat whose readings moved goes from
// acceptance through the DIR, WALK and DONE states to the result register,
// walking n levels (0 to NUM_LEVELS - 1); unchanged readings skip WALK. The level
// sequencer moves one level per cycle, and the next beat can be taken in the
// cycle after the result is loaded.
// Reset clears the level and the stored readings to zero.
// A stalled result holds in the output register; the next beat is accepted
// while it waits and finishes once the register is free.
`timescale 1ns / 1ps
`default_nettype none

module fan_level_hysteresis_table_unit #(
  parameter int NUM_LEVELS = flht_pkg::NUM_LEVELS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire flht_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output flht_pkg::out_t      out_data
);

  localparam int LW = $clog2(NUM_LEVELS);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIR  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // Walk directions.
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;
  localparam logic [1:0] DIR_UP   = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [1:0]          dir_r, dir_nxt;
  logic [LW-1:0]       level_r, level_nxt;
  flht_pkg::temp_t     last_temps_r [flht_pkg::NUM_SENSORS];
  flht_pkg::temp_t     temps_r      [flht_pkg::NUM_SENSORS];
  logic                chan_r;
  logic                mode_r;
  logic                out_valid_r, out_valid_nxt;
  flht_pkg::out_t      out_data_r;

  logic [4:0]          level_ext;
  logic [2:0]          row;
  logic                at_top;
  logic                load_out;
  logic                in_fire;

  flht_pkg::lane_flags_t lane_flags [flht_pkg::NUM_SENSORS];
  flht_pkg::step_ctl_t   ctl;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Levels beyond the table use the last row.
  assign level_ext = 5'(level_r);
  assign row       = (level_ext > 5'(flht_pkg::TABLE_LEVELS - 1)) ?
                     3'(flht_pkg::TABLE_LEVELS - 1) : level_ext[2:0];
  assign at_top    = (level_r == LW'(NUM_LEVELS - 1));

  // Sensor lanes work side by side on the three readings of the beat.
  for (genvar g = 0; g < flht_pkg::NUM_SENSORS; g++) begin : g_lane
    flht_lane u_lane (
      .temp      (temps_r[g]),
      .last_temp (last_temps_r[g]),
      .trip      (flht_pkg::TRIP_TAB[mode_r][row][g]),
      .rel       (flht_pkg::REL_TAB[mode_r][row][g]),
      .flags     (lane_flags[g])
    );
  end

  flht_merge u_merge (
    .lane_first  (lane_flags[0]),
    .lane_third  (lane_flags[1]),
    .lane_fourth (lane_flags[2]),
    .ctl         (ctl)
  );

  // The result register takes a new value in ST_DONE when it is empty or being drained.
  assign load_out = (state_r == ST_DONE) & (~out_valid_r | out_ready);

  // Level sequencer.
  always_comb begin
    state_nxt = state_r;
    dir_nxt   = dir_r;
    level_nxt = level_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_DIR;
        end
      end
      ST_DIR: begin
        if (ctl.fell) begin
          dir_nxt   = DIR_DOWN;
          state_nxt = ST_WALK;
        end else if (ctl.rose) begin
          dir_nxt   = DIR_UP;
          state_nxt = ST_WALK;
        end else begin
          dir_nxt   = DIR_NONE;
          state_nxt = ST_DONE;
        end
      end
      ST_WALK: begin
        if (dir_r == DIR_DOWN) begin
          if ((level_r != '0) && ctl.step_down) begin
            level_nxt = level_r - LW'(1);
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          // Stepping past the top level saturates there.
          if (ctl.step_up && !at_top) begin
            level_nxt = level_r + LW'(1);
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dir_r       <= DIR_NONE;
      level_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < flht_pkg::NUM_SENSORS; i++) begin
        last_temps_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      dir_r       <= dir_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
      // The readings become the new reference once the direction is known.
      if (state_r == ST_DIR) begin
        for (int i = 0; i < flht_pkg::NUM_SENSORS; i++) begin
          last_temps_r[i] <= temps_r[i];
        end
      end
    end
  end

  // Beat capture and result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      chan_r     <= in_data.fan_channel;
      mode_r     <= in_data.tablet_sel;
      temps_r[0] <= in_data.temp_first;
      temps_r[1] <= in_data.temp_third;
      temps_r[2] <= in_data.temp_fourth;
    end
    if (load_out) begin
      out_data_r.target_rpm <= flht_pkg::RPM_TAB[mode_r][row][chan_r];
      out_data_r.fan_level  <= level_ext[2:0];
    end
  end

endmodule

`default_nettype wire

[rtl/flht_checker.sv]
// Port-level checker for the fan level hysteresis unit, bound to the top
// level. Uses flht_pkg for the beat types.
`timescale 1ns / 1ps
`default_nettype none

module flht_port_checker #(
  parameter int NUM_LEVELS = flht_pkg::NUM_LEVELS_DEF
) (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire flht_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire flht_pkg::out_t out_data
);

  // A pending result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // A pending result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result beat changed while stalled");

  // Only one beat is in flight: input closes right after a beat is taken.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted a second beat while busy");

  // While NUM_LEVELS is at most 8, the reported level never exceeds the top level.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (NUM_LEVELS > 8) || (out_data.fan_level <= 3'(NUM_LEVELS - 1)))
    else $error("fan level out of range");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result pending after reset");

endmodule

bind fan_level_hysteresis_table_unit flht_port_checker #(.NUM_LEVELS(NUM_LEVELS))
  u_flht_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

[tb/sv/flht_checker.sv]
// Scoreboard for the fan level hysteresis unit: watches both channels, keeps
// its own fan level state and checks every result beat. Depends on flht_pkg.
`timescale 1ns / 1ps

module flht_checker #(
  parameter int NUM_LEVELS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  flht_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  flht_pkg::out_t out_data,
  output int             err_count,
  output int             outstanding,
  output int             checked,
  output logic [7:0]     levels_seen
);

  localparam int MAX_PRINTS = 50;

  // Trigger points per mode and level, sensor order first, third, fourth.
  localparam int FAN_TRIP [2][8][3] = '{
    '{ '{0, 54, 34}, '{0, 57, 35}, '{0, 58, 36}, '{0, 59, 37},
       '{60, 60, 38}, '{62, 61, 39}, '{65, 64, 40}, '{100, 100, 100} },
    '{ '{0, 55, 39}, '{0, 56, 40}, '{0, 57, 41}, '{0, 58, 42},
       '{60, 59, 43}, '{62, 60, 44}, '{65, 61, 45}, '{100, 100, 100} }
  };

  // Release points per mode and level, same sensor order.
  localparam int FAN_REL [2][8][3] = '{
    '{ '{99, 99, 99}, '{99, 54, 34}, '{99, 57, 35}, '{99, 58, 36},
       '{58, 59, 37}, '{60, 60, 38}, '{62, 61, 39}, '{65, 62, 40} },
    '{ '{99, 99, 99}, '{99, 55, 39}, '{99, 56, 40}, '{99, 57, 41},
       '{58, 58, 42}, '{60, 59, 43}, '{62, 60, 44}, '{65, 61, 45} }
  };

  // Target speed per mode, level and fan channel.
  localparam int FAN_RPM [2][8][2] = '{
    '{ '{0, 0}, '{3950, 3850}, '{4200, 4100}, '{4550, 4450},
       '{4900, 4800}, '{5250, 5150}, '{5400, 5300}, '{6000, 6150} },
    '{ '{0, 0}, '{0, 0}, '{4000, 3350}, '{4200, 3400},
       '{4400, 3500}, '{4800, 4350}, '{5000, 4500}, '{5200, 5100} }
  };

  int             fan_lvl;
  int             prev_temp [3];
  int             n_err;
  flht_pkg::out_t speed_q [$];

  // Levels past the end of the tables reuse the top row.
  function automatic int table_row(int lv);
    return (lv > 7) ? 7 : lv;
  endfunction

  // Apply one reading set to the level and return the speed it selects.
  function automatic flht_pkg::out_t advance_fan_level(flht_pkg::in_t b);
    int             t [3];
    int             m;
    int             row;
    bit             fell;
    bit             rose;
    bit             walking;
    flht_pkg::out_t r;
    t[0] = int'($signed(b.temp_first));
    t[1] = int'($signed(b.temp_third));
    t[2] = int'($signed(b.temp_fourth));
    m = int'(b.tablet_sel);
    fell = 1'b0;
    rose = 1'b0;
    if (fan_lvl > NUM_LEVELS - 1) fan_lvl = NUM_LEVELS - 1;
    for (int k = 0; k < 3; k++) begin
      if (t[k] < prev_temp[k]) fell = 1'b1;
      if (t[k] > prev_temp[k]) rose = 1'b1;
    end
    walking = 1'b1;
    if (fell) begin
      // Any falling reading: release downward while all three are below.
      while (walking && fan_lvl > 0) begin
        row = table_row(fan_lvl);
        if (t[0] < FAN_REL[m][row][0] && t[2] < FAN_REL[m][row][2] &&
            t[1] < FAN_REL[m][row][1]) begin
          fan_lvl--;
        end else begin
          walking = 1'b0;
        end
      end
    end else if (rose) begin
      // Rising only: trigger upward on first and fourth together, or third.
      while (walking && fan_lvl < NUM_LEVELS) begin
        row = table_row(fan_lvl);
        if ((t[0] > FAN_TRIP[m][row][0] && t[2] > FAN_TRIP[m][row][2]) ||
            t[1] > FAN_TRIP[m][row][1]) begin
          fan_lvl++;
        end else begin
          walking = 1'b0;
        end
      end
      if (fan_lvl > NUM_LEVELS - 1) fan_lvl = NUM_LEVELS - 1;
    end
    prev_temp = t;
    row = table_row(fan_lvl);
    r.target_rpm = 16'(FAN_RPM[m][row][b.fan_channel]);
    r.fan_level  = 3'(fan_lvl);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (n_err < MAX_PRINTS) begin
      $display("MISMATCH at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
    end
    n_err++;
  endtask

  // Watch both channels at each edge; results are matched before new beats.
  always @(posedge clk) begin
    flht_pkg::out_t want;
    if (!rst_n) begin
      fan_lvl = 0;
      prev_temp = '{0, 0, 0};
      n_err = 0;
      speed_q.delete();
      err_count   <= 0;
      outstanding <= 0;
      checked     <= 0;
      levels_seen <= '0;
    end else begin
      if (out_valid && out_ready) begin
        if (speed_q.size() == 0) begin
          report_mismatch("result beat with nothing pending, target_rpm",
                          int'(out_data.target_rpm), -1);
        end else begin
          want = speed_q.pop_front();
          if (out_data.target_rpm !== want.target_rpm) begin
            report_mismatch("target_rpm", int'(out_data.target_rpm), int'(want.target_rpm));
          end
          if (out_data.fan_level !== want.fan_level) begin
            report_mismatch("fan_level", int'(out_data.fan_level), int'(want.fan_level));
          end
          checked <= checked + 1;
          levels_seen[want.fan_level] <= 1'b1;
        end
      end
      if (in_valid && in_ready) begin
        speed_q.push_back(advance_fan_level(in_data));
      end
      err_count   <= n_err;
      outstanding <= speed_q.size();
    end
  end

endmodule

[tb/sv/tb_fan_level_hysteresis_table_unit.sv]
// Testbench top for the fan level hysteresis unit: clock, reset, stimulus and
// verdict. Depends on flht_pkg, fan_level_hysteresis_table_unit and flht_checker.
`timescale 1ns / 1ps

module tb_fan_level_hysteresis_table_unit;

  localparam int NUM_LEVELS   = 8;
  localparam int RANDOM_BEATS = 1850;
  localparam bit CLAMSHELL    = 1'b0;
  localparam bit TABLET       = 1'b1;
  localparam bit FAN_A        = 1'b0;
  localparam bit FAN_B        = 1'b1;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  flht_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  flht_pkg::out_t out_data;
  logic           calm;
  int             err_count;
  int             outstanding;
  int             checked;
  logic [7:0]     levels_seen;
  int             n_sent;

  always #5 clk = ~clk;

  fan_level_hysteresis_table_unit #(
    .NUM_LEVELS(NUM_LEVELS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  flht_checker #(
    .NUM_LEVELS(NUM_LEVELS)
  ) speed_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .err_count  (err_count),
    .outstanding(outstanding),
    .checked    (checked),
    .levels_seen(levels_seen)
  );

  // Mostly short gaps, now and then a long one; none while calm.
  function automatic int idle_len(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int clamp_temp(int v);
    if (v > 127) return 127;
    if (v < -128) return -128;
    return v;
  endfunction

  function automatic flht_pkg::in_t mk_beat(bit chan, bit mode, int t1, int t3, int t4);
    flht_pkg::in_t b;
    b.fan_channel = chan;
    b.tablet_sel  = mode;
    b.temp_first  = 8'(t1);
    b.temp_third  = 8'(t3);
    b.temp_fourth = 8'(t4);
    return b;
  endfunction

  // Offer one beat after an optional gap and hold it until it is taken.
  task automatic send_beat(flht_pkg::in_t b, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  // Result side: bursts of ready broken by random stalls.
  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (n) @(posedge clk);
      n = idle_len(calm);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int  w1;
    int  w3;
    int  w4;
    int  r;
    bit  wmode;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    calm     <= 1'b0;
    n_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unchanged readings at reset, saturation at the top, walk to
    // the bottom, the third sensor alone, the first and fourth together,
    // hysteresis holding, falling taking priority, and both tables.
    send_beat(mk_beat(FAN_A, CLAMSHELL, 0, 0, 0), 0);
    send_beat(mk_beat(FAN_A, CLAMSHELL, 127, 127, 127), 0);
    send_beat(mk_beat(FAN_B, CLAMSHELL, 127, 127, 127), idle_len(1'b0));
    send_beat(mk_beat(FAN_A, CLAMSHELL, -128, -128, -128), 0);
    send_beat(mk_beat(FAN_B, CLAMSHELL, -128, -128, -128), idle_len(1'b0));
    send_beat(mk_beat(FAN_A, CLAMSHELL, -128, 58, -128), 0);
    send_beat(mk_beat(FAN_B, CLAMSHELL, 61, 58, 39), 0);
    send_beat(mk_beat(FAN_A, CLAMSHELL, 61, 50, 39), idle_len(1'b0));
    send_beat(mk_beat(FAN_B, CLAMSHELL, 59, 50, 37), 0);
    send_beat(mk_beat(FAN_B, TABLET, 59, 50, 37), 0);
    send_beat(mk_beat(FAN_A, TABLET, 127, 0, 37), idle_len(1'b0));
    send_beat(mk_beat(FAN_A, TABLET, -128, -128, -128), 0);
    send_beat(mk_beat(FAN_B, TABLET, -128, 56, -128), 0);
    send_beat(mk_beat(FAN_A, TABLET, 100, 100, 100), idle_len(1'b0));
    send_beat(mk_beat(FAN_B, TABLET, 101, 101, 101), 0);
    send_beat(mk_beat(FAN_A, CLAMSHELL, 101, 101, 101), 0);
    send_beat(mk_beat(FAN_B, CLAMSHELL, 127, -128, 127), 0);
    send_beat(mk_beat(FAN_A, CLAMSHELL, -128, 127, -128), idle_len(1'b0));
    send_beat(mk_beat(FAN_B, TABLET, 0, -1, 0), 0);
    send_beat(mk_beat(FAN_A, TABLET, 66, 62, 46), 0);

    // Random: temperature walks around the thresholds with jumps and noise.
    w1 = 45;
    w3 = 50;
    w4 = 38;
    wmode = CLAMSHELL;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      calm <= ((i / 200) % 4 == 3);
      if (i % 300 == 150) begin
        // Let the unit drain completely before going on.
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        w1 = int'($urandom_range(0, 255)) - 128;
        w3 = int'($urandom_range(0, 255)) - 128;
        w4 = int'($urandom_range(0, 255)) - 128;
      end else if (r < 15) begin
        // Readings repeat unchanged.
      end else if (r < 20) begin
        w1 = $urandom_range(60, 127);
        w3 = $urandom_range(60, 127);
        w4 = $urandom_range(40, 127);
      end else if (r < 25) begin
        w1 = int'($urandom_range(0, 158)) - 128;
        w3 = int'($urandom_range(0, 158)) - 128;
        w4 = int'($urandom_range(0, 158)) - 128;
      end else begin
        w1 = clamp_temp(w1 + int'($urandom_range(0, 8)) - 4);
        w3 = clamp_temp(w3 + int'($urandom_range(0, 8)) - 4);
        w4 = clamp_temp(w4 + int'($urandom_range(0, 8)) - 4);
        if (w1 < 20 || w1 > 80) w1 = $urandom_range(30, 70);
        if (w3 < 20 || w3 > 80) w3 = $urandom_range(30, 70);
        if (w4 < 20 || w4 > 80) w4 = $urandom_range(28, 50);
      end
      if ($urandom_range(0, 99) < 4) wmode = ~wmode;
      send_beat(mk_beat(1'($urandom_range(0, 1)), wmode, w1, w3, w4),
                idle_len((i / 200) % 4 == 3));
    end
    in_valid <= 1'b0;

    // Drain, then keep the clock running so that anything stray still shows.
    do @(posedge clk); while (outstanding != 0);
    repeat (30) @(posedge clk);

    $display("Summary: %0d beats sent, %0d results checked, levels reached %b.",
             n_sent, checked, levels_seen);
    $display("Covered directed edge cases and random walks in both tables with stalls.");
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[filelist.f]
rtl/flht_pkg.sv
rtl/flht_lane.sv
rtl/flht_merge.sv
rtl/fan_level_hysteresis_table_unit.sv
rtl/flht_checker.sv
tb/sv/flht_checker.sv
tb/sv/tb_fan_level_hysteresis_table_unit.sv
